@@ rtl/core/bmd_pkg.sv @@
// Shared types and constants for the block mode decryptor.
package bmd_pkg;

    localparam int BLK_W     = 64;
    localparam int MODE_W    = 3;
    localparam int CFG_IDX_W = 3;

    // Mode codes; any other code passes data through.
    localparam logic [MODE_W-1:0] CM_ECB = 3'd1;
    localparam logic [MODE_W-1:0] CM_CBC = 3'd2;
    localparam logic [MODE_W-1:0] CM_CFB = 3'd3;
    localparam logic [MODE_W-1:0] CM_OFB = 3'd4;
    localparam logic [MODE_W-1:0] CM_CTR = 3'd5;

    // Pass-through codes.
    localparam logic [MODE_W-1:0] CM_NONE  = 3'd0;
    localparam logic [MODE_W-1:0] CM_RSVD6 = 3'd6;
    localparam logic [MODE_W-1:0] CM_RSVD7 = 3'd7;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IV   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CTR  = 3'd3;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [BLK_W-1:0]  key;
        logic [BLK_W-1:0]  iv;
        logic [BLK_W-1:0]  ctr;
    } t_cfg;

endpackage

@@ rtl/core/bmd_cfg.sv @@
// Configuration register file for the block mode decryptor.
module bmd_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bmd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bmd_pkg::BLK_W-1:0]      i_cfg_data,
    output bmd_pkg::t_cfg                  o_cfg
);
    import bmd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE: r_cfg.mode <= i_cfg_data[MODE_W-1:0];
                CFG_KEY:  r_cfg.key  <= i_cfg_data;
                CFG_IV:   r_cfg.iv   <= i_cfg_data;
                CFG_CTR:  r_cfg.ctr  <= i_cfg_data;
                default:  ;  // unused index, dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/core/bmd_core.sv @@
// Combinational decrypt datapath: plaintext and next chaining value.
module bmd_core (
    input  bmd_pkg::t_cfg              i_cfg,
    input  logic [bmd_pkg::BLK_W-1:0]  i_chain,
    input  logic [bmd_pkg::BLK_W-1:0]  i_blk,
    input  logic                       i_som,
    output logic [bmd_pkg::BLK_W-1:0]  o_plain,
    output logic [bmd_pkg::BLK_W-1:0]  o_chain
);
    import bmd_pkg::*;

    logic [BLK_W-1:0] v;
    logic [BLK_W-1:0] ks;

    always_comb begin
        // start of message reloads chain before use
        if (i_som) begin
            v = (i_cfg.mode == CM_CTR) ? i_cfg.ctr : i_cfg.iv;
        end else begin
            v = i_chain;
        end
        ks      = v ^ i_cfg.key;
        o_plain = i_blk;
        o_chain = v;
        case (i_cfg.mode)
            CM_ECB: begin
                o_plain = i_blk ^ i_cfg.key;
            end
            CM_CBC, CM_CFB: begin
                o_plain = i_blk ^ ks;
                o_chain = i_blk;
            end
            CM_OFB: begin
                o_plain = i_blk ^ ks;
                o_chain = ks;
            end
            CM_CTR: begin
                o_plain = i_blk ^ ks;
                // low byte wraps, no carry into byte 6
                o_chain = {v[BLK_W-1:8], v[7:0] + 8'd1};
            end
            default: ;  // pass-through
        endcase
    end

endmodule

@@ rtl/core/block_mode_decryptor.sv @@
// Top level of the block mode decryptor: input stage, chain register, result stage.
//
// Decrypts one 64-bit ciphertext word per cycle while the output is not
// stalled (byte 0 in bits 63:56) in ECB, CBC, CFB, OFB or CTR mode with an
// XOR block cipher; mode codes 0, 6 and 7 pass the word through. Each accepted
// word lands in an input register; in the next cycle the datapath computes the
// plaintext and the new chaining value, which are captured in the result
// register and the chain register at the same edge, so consecutive words chain
// correctly with no bubble. Output valid is registered: a word passes the input
// register and then the result register (two register stages), and sustained
// throughput is one word per cycle while the output is not stalled. The input
// register keeps taking words while a finished word waits in the result
// register; the input stall rises only when both stages are full and the output
// is stalled. Start of message reloads the chain from the counter start in CTR
// mode and from the IV otherwise. Configuration is written through a plain
// write port and must only change while the block is idle.
module block_mode_decryptor (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bmd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bmd_pkg::BLK_W-1:0]      i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [bmd_pkg::BLK_W-1:0]      i_cipher_block,
    input  logic                           i_start_of_message,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [bmd_pkg::BLK_W-1:0]      o_plain_block
);
    import bmd_pkg::*;

    t_cfg             cfg;
    logic             r_in_vld;
    logic [BLK_W-1:0] r_blk;
    logic             r_som;
    logic             r_out_vld;
    logic [BLK_W-1:0] r_plain;
    logic [BLK_W-1:0] r_chain;
    logic [BLK_W-1:0] n_plain;
    logic [BLK_W-1:0] n_chain;
    logic             out_free;
    logic             adv;
    logic             in_take;

    bmd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    bmd_core u_core (
        .i_cfg   (cfg),
        .i_chain (r_chain),
        .i_blk   (r_blk),
        .i_som   (r_som),
        .o_plain (n_plain),
        .o_chain (n_chain)
    );

    // Result stage can load when empty or being drained this cycle.
    assign out_free   = !r_out_vld || !i_out_stall;
    assign adv        = r_in_vld && out_free;
    assign o_in_stall = r_in_vld && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_blk <= i_cipher_block;
            r_som <= i_start_of_message;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_plain <= n_plain;
        end
    end

    // Chain advances exactly once per word moved into the result stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= '0;
        end else if (adv) begin
            r_chain <= n_chain;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_plain_block = r_plain;

    a_chain_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_chain))
        else $error("chain changed without a word advancing");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_vld && r_out_vld && i_out_stall))
        else $error("input stalled while a stage is free");

    a_adv_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_vld)
        else $error("advanced word did not reach the result stage");

    a_ecb_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && !r_som && (cfg.mode == CM_ECB || cfg.mode == CM_NONE ||
         cfg.mode == CM_RSVD6 || cfg.mode == CM_RSVD7)) |=> $stable(r_chain))
        else $error("chain moved in a non-chaining mode");

endmodule
